[hw/rtl/vdhc_pkg.sv]
`timescale 1ns / 1ps
package vdhc_pkg;

	localparam int unsigned SQRT_STAGES = 32;
	localparam int unsigned DIV_STAGES  = 17;
	localparam int unsigned REM_W       = 36;
	localparam logic [16:0] ONE_Q16     = 17'h10000;

	localparam logic REG_MAX_SPEED   = 1'b0;
	localparam logic REG_MAX_DENSITY = 1'b1;

	localparam logic [15:0] MAX_SPEED_RST   = 16'd7680;
	localparam logic [15:0] MAX_DENSITY_RST = 16'd25600;

	typedef struct packed {
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic signed [15:0] vel_z;
		logic signed [15:0] density;
	} vdhc_in_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} vdhc_out_t;

endpackage

[hw/rtl/velocity_density_heatmap_color_top.sv]
`timescale 1ns / 1ps
// channel  direction  handshake                  payload
// in       input      in_valid / in_ready        in_data (vel_x, vel_y, vel_z, density)
// out      output     out_valid / out_ready      out_data (red, green, blue)
// cfg      input      cfg_we                     cfg_index, cfg_data
//
// One request per cycle unless a held result stalls the pipeline; stages: 2 square/sum, 32 root,
// 1 range check, 17 divide, 1 ramp, 1 multiply, output register.
// The root stages (one result bit each) and divide stages set the depth.
// arst_n clears valid bits and loads the register reset values.
// A held result stalls the whole pipeline; nothing is dropped or repeated.
module velocity_density_heatmap_color_top
	import vdhc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  vdhc_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output vdhc_out_t out_data,
	input  logic      cfg_we,
	input  logic      cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] max_speed_q, max_density_q;
	logic        adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q   <= MAX_SPEED_RST;
			max_density_q <= MAX_DENSITY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_SPEED:   max_speed_q   <= cfg_data;
				REG_MAX_DENSITY: max_density_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// squares
	logic        v_s1;
	logic [30:0] sqx_s1, sqy_s1, sqz_s1;
	logic signed [15:0] dn_s1;
	logic signed [31:0] px, py, pz;

	assign px = in_data.vel_x * in_data.vel_x;
	assign py = in_data.vel_y * in_data.vel_y;
	assign pz = in_data.vel_z * in_data.vel_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s1 <= px[30:0];
			sqy_s1 <= py[30:0];
			sqz_s1 <= pz[30:0];
			dn_s1  <= in_data.density;
		end
	end

	// sum
	logic        v_s2;
	logic [31:0] sum_s2;
	logic signed [15:0] dn_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2 <= 32'(sqx_s1) + 32'(sqy_s1) + 32'(sqz_s1);
			dn_s2  <= dn_s1;
		end
	end

	// square root, one result bit per stage
	logic              sq_v_s   [SQRT_STAGES+1];
	logic [REM_W-1:0]  sq_rem_s [SQRT_STAGES+1];
	logic [31:0]       sq_root_s[SQRT_STAGES+1];
	logic [31:0]       sq_sum_s [SQRT_STAGES+1];
	logic signed [15:0] sq_dn_s [SQRT_STAGES+1];

	assign sq_v_s[0]    = v_s2;
	assign sq_rem_s[0]  = '0;
	assign sq_root_s[0] = '0;
	assign sq_sum_s[0]  = sum_s2;
	assign sq_dn_s[0]   = dn_s2;

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
		localparam int unsigned I = SQRT_STAGES - 1 - k;
		logic [1:0]       pair;
		logic [REM_W-1:0] rem_sh, trial;
		logic             take;

		if (I >= 16) begin : g_hi
			assign pair = sq_sum_s[k][2*(I-16)+1 -: 2];
		end else begin : g_lo
			assign pair = 2'b00;
		end

		assign rem_sh = {sq_rem_s[k][REM_W-3:0], pair};
		assign trial  = REM_W'({sq_root_s[k], 2'b01});
		assign take   = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v_s[k+1] <= 1'b0;
			else if (adv) sq_v_s[k+1] <= sq_v_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_rem_s[k+1]  <= take ? rem_sh - trial : rem_sh;
				sq_root_s[k+1] <= {sq_root_s[k][30:0], take};
				sq_sum_s[k+1]  <= sq_sum_s[k];
				sq_dn_s[k+1]   <= sq_dn_s[k];
			end
		end
	end

	// range check and divide setup
	logic        v_s3;
	logic        ts_ovr_s3, dd_ovr_s3;
	logic [16:0] ts_ovr_val_s3, dd_ovr_val_s3;
	logic [31:0] ts_num_s3, dd_num_s3;
	logic [31:0] root;
	logic [31:0] dnum;

	assign root = sq_root_s[SQRT_STAGES];
	assign dnum = (sq_dn_s[SQRT_STAGES] > 0) ? {sq_dn_s[SQRT_STAGES], 16'h0000} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= sq_v_s[SQRT_STAGES];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ts_ovr_s3     <= (max_speed_q == '0) || (16'(root[31:17]) >= max_speed_q);
			ts_ovr_val_s3 <= (root == '0) ? '0 : ONE_Q16;
			ts_num_s3     <= root;
			dd_ovr_s3     <= (max_density_q == '0) || (16'(dnum[31:17]) >= max_density_q);
			dd_ovr_val_s3 <= (dnum == '0) ? '0 : ONE_Q16;
			dd_num_s3     <= dnum;
		end
	end

	// restoring division, one quotient bit per stage
	logic        dv_v_s   [DIV_STAGES+1];
	logic [16:0] ts_r_s   [DIV_STAGES+1];
	logic [16:0] ts_q_s   [DIV_STAGES+1];
	logic [16:0] ts_n_s   [DIV_STAGES+1];
	logic        ts_o_s   [DIV_STAGES+1];
	logic [16:0] ts_ov_s  [DIV_STAGES+1];
	logic [16:0] dd_r_s   [DIV_STAGES+1];
	logic [16:0] dd_q_s   [DIV_STAGES+1];
	logic [16:0] dd_n_s   [DIV_STAGES+1];
	logic        dd_o_s   [DIV_STAGES+1];
	logic [16:0] dd_ov_s  [DIV_STAGES+1];

	assign dv_v_s[0]  = v_s3;
	assign ts_r_s[0]  = {2'b00, ts_num_s3[31:17]};
	assign ts_q_s[0]  = '0;
	assign ts_n_s[0]  = ts_num_s3[16:0];
	assign ts_o_s[0]  = ts_ovr_s3;
	assign ts_ov_s[0] = ts_ovr_val_s3;
	assign dd_r_s[0]  = {2'b00, dd_num_s3[31:17]};
	assign dd_q_s[0]  = '0;
	assign dd_n_s[0]  = dd_num_s3[16:0];
	assign dd_o_s[0]  = dd_ovr_s3;
	assign dd_ov_s[0] = dd_ovr_val_s3;

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
		localparam int unsigned B = DIV_STAGES - 1 - j;
		logic [16:0] ts_sh, dd_sh;
		logic        ts_take, dd_take;

		assign ts_sh   = {ts_r_s[j][15:0], ts_n_s[j][B]};
		assign dd_sh   = {dd_r_s[j][15:0], dd_n_s[j][B]};
		assign ts_take = ts_sh >= {1'b0, max_speed_q};
		assign dd_take = dd_sh >= {1'b0, max_density_q};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[j+1] <= 1'b0;
			else if (adv) dv_v_s[j+1] <= dv_v_s[j];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ts_r_s[j+1]  <= ts_take ? ts_sh - {1'b0, max_speed_q} : ts_sh;
				ts_q_s[j+1]  <= ts_q_s[j] | (17'(ts_take) << B);
				ts_n_s[j+1]  <= ts_n_s[j];
				ts_o_s[j+1]  <= ts_o_s[j];
				ts_ov_s[j+1] <= ts_ov_s[j];
				dd_r_s[j+1]  <= dd_take ? dd_sh - {1'b0, max_density_q} : dd_sh;
				dd_q_s[j+1]  <= dd_q_s[j] | (17'(dd_take) << B);
				dd_n_s[j+1]  <= dd_n_s[j];
				dd_o_s[j+1]  <= dd_o_s[j];
				dd_ov_s[j+1] <= dd_ov_s[j];
			end
		end
	end

	// hue ramp
	logic [16:0] t_val, d_val, inv_t, f_val, x_val;
	logic [18:0] h_val;
	logic [2:0]  sext;
	logic [16:0] cr, cg, cb;

	assign t_val = ts_o_s[DIV_STAGES] ? ts_ov_s[DIV_STAGES] :
		(ts_q_s[DIV_STAGES] > ONE_Q16) ? ONE_Q16 : ts_q_s[DIV_STAGES];
	assign d_val = dd_o_s[DIV_STAGES] ? dd_ov_s[DIV_STAGES] :
		(dd_q_s[DIV_STAGES] > ONE_Q16) ? ONE_Q16 : dd_q_s[DIV_STAGES];
	assign inv_t = ONE_Q16 - t_val;
	assign h_val = {inv_t, 2'b00};
	assign sext  = h_val[18:16];
	assign f_val = {1'b0, h_val[15:0]};
	assign x_val = sext[0] ? ONE_Q16 - f_val : f_val;

	always_comb begin
		case (sext)
			3'd0:    begin cr = ONE_Q16; cg = x_val;   cb = '0;      end
			3'd1:    begin cr = x_val;   cg = ONE_Q16; cb = '0;      end
			3'd2:    begin cr = '0;      cg = ONE_Q16; cb = x_val;   end
			3'd3:    begin cr = '0;      cg = x_val;   cb = ONE_Q16; end
			3'd4:    begin cr = x_val;   cg = '0;      cb = ONE_Q16; end
			default: begin cr = ONE_Q16; cg = '0;      cb = x_val;   end
		endcase
	end

	logic        v_s4;
	logic [16:0] cr_s4, cg_s4, cb_s4, d_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= dv_v_s[DIV_STAGES];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cr_s4 <= cr;
			cg_s4 <= cg;
			cb_s4 <= cb;
			d_s4  <= d_val;
		end
	end

	// channel times density
	logic        v_s5;
	logic [33:0] pr_s5, pg_s5, pb_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pr_s5 <= cr_s4 * d_s4;
			pg_s5 <= cg_s4 * d_s4;
			pb_s5 <= cb_s4 * d_s4;
		end
	end

	// times 255, keep bits 39:32
	logic [41:0] sr, sg, sb;

	assign sr = {pr_s5, 8'h00} - 42'(pr_s5);
	assign sg = {pg_s5, 8'h00} - 42'(pg_s5);
	assign sb = {pb_s5, 8'h00} - 42'(pb_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.red   <= sr[39:32];
			out_data.green <= sg[39:32];
			out_data.blue  <= sb[39:32];
		end
	end

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("input taken while output stalled");

	a_sextant_range: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v_s[DIV_STAGES] |-> (sext <= 3'd4))
		else $error("hue sextant out of range");

	a_ratio_limit: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (d_s4 <= ONE_Q16))
		else $error("density ratio above one");

endmodule
